>>> design/hcbp_pkg.sv
// Package for the Huffman code bit packer: widths, command/status structs and
// the controller state type. No dependencies.
package hcbp_pkg;

    localparam int CODE_W           = 16;
    localparam int LEN_W            = 5;
    localparam int TREE_W           = 13;
    localparam int BYTE_W           = 8;
    localparam int PAD_W            = 3;
    localparam int WIN_W            = 24;
    localparam int QUEUE_DEPTH      = 3;
    localparam int CNT_W            = 2;
    localparam int MAX_CODE_LEN_DEF = 16;

    typedef enum logic
    {
        ST_IDLE,
        ST_SEND
    } state_t;

    // Controller to datapath
    typedef struct packed
    {
        logic load;
        logic advance;
    } cmd_t;

    // Datapath to controller
    typedef struct packed
    {
        logic has_results;
        logic last_slot;
    } status_t;

endpackage

>>> design/hcbp_item_if.sv
// Input channel of the Huffman code bit packer: valid/ready plus one item.
// Depends on hcbp_pkg.
interface hcbp_item_if
    import hcbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, output func, output code_bits, output code_length,
                    input ready);
    modport sink   (input valid, input func, input code_bits, input code_length,
                    output ready);
endinterface

>>> design/hcbp_result_if.sv
// Output channel of the Huffman code bit packer: valid/ready plus one byte.
// Depends on hcbp_pkg.
interface hcbp_result_if
    import hcbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_header;
    logic              last;

    modport source (output valid, output out_byte, output is_header, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_header, input last,
                    output ready);
endinterface

>>> design/hcbp_ctrl.sv
// Controller of the Huffman code bit packer: accept an item, then send its
// bytes one per handshake. Depends on hcbp_pkg.
module hcbp_ctrl
    import hcbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && status.has_results)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (cmd.advance && status.last_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshakes and commands
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
            end
        endcase
        cmd.load    = in_valid && in_ready;
        cmd.advance = out_valid && out_ready;
    end

    // Never take an item and send a word in the same cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.advance))
        else $error("load and advance together");

    // An item with no results leaves the controller ready
    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !status.has_results) |=> in_ready)
        else $error("empty item blocked input");

    // After the final word goes out, input opens again
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && status.last_slot) |=> (in_ready && !out_valid))
        else $error("did not return to idle");

endmodule

>>> design/hcbp_datapath.sv
// Datapath of the Huffman code bit packer: bit window, packing state, output
// byte queue and tree size register. Depends on hcbp_pkg.
module hcbp_datapath
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic              func,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    input  logic              cfg_we,
    input  logic [TREE_W-1:0] cfg_wdata,
    output logic [BYTE_W-1:0] out_byte,
    output logic              is_header,
    output logic              last
);

    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int SH_W    = $clog2(WIN_W + 1);

    logic [TREE_W-1:0] tree_len_reg;
    logic [BYTE_W-1:0] partial_reg;
    logic [BYTE_W-1:0] partial_next;
    logic [PAD_W-1:0]  pending_reg;
    logic [PAD_W-1:0]  pending_next;
    logic [BYTE_W-1:0] q_byte_reg [QUEUE_DEPTH];
    logic [BYTE_W-1:0] q_byte_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] q_hdr_reg;
    logic [QUEUE_DEPTH-1:0] q_hdr_next;
    logic [CNT_W-1:0]  q_cnt_reg;
    logic [CNT_W-1:0]  q_cnt_next;

    logic [LEN_W-1:0]  eff_len;
    logic [CODE_W-1:0] code_mask;
    logic [CODE_W-1:0] code_m;
    logic [SH_W-1:0]   shamt;
    logic [WIN_W-1:0]  window;
    logic [LEN_W-1:0]  total;
    logic [CNT_W-1:0]  nbytes;
    logic [PAD_W-1:0]  pad;
    logic [2*BYTE_W-1:0] hdr_word;

    // Clamp the length and place the code just under the pending bits
    always_comb
    begin
        eff_len   = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;
        code_mask = CODE_W'(((CODE_W+1)'(1) << eff_len) - (CODE_W+1)'(1));
        code_m    = code_bits & code_mask;
        shamt     = SH_W'(WIN_W) - SH_W'(pending_reg) - SH_W'(eff_len);
        window    = {partial_reg, {(WIN_W-BYTE_W){1'b0}}}
                  | (WIN_W'(code_m) << shamt);
        total     = LEN_W'(pending_reg) + eff_len;
        nbytes    = total[LEN_W-1:PAD_W];
        pad       = PAD_W'(4'd8 - {1'b0, pending_reg});
        hdr_word  = {pad, tree_len_reg};
    end

    assign status.has_results = func || (nbytes != '0);
    assign status.last_slot   = (q_cnt_reg == CNT_W'(1));

    assign out_byte  = q_byte_reg[0];
    assign is_header = q_hdr_reg[0];
    assign last      = status.last_slot;

    // Load a new item or drop the word just sent
    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        q_byte_next  = q_byte_reg;
        q_hdr_next   = q_hdr_reg;
        q_cnt_next   = q_cnt_reg;
        if (cmd.load)
        begin
            if (func)
            begin
                partial_next = '0;
                pending_next = '0;
                if (pending_reg != '0)
                begin
                    q_byte_next[0] = partial_reg;
                    q_byte_next[1] = hdr_word[2*BYTE_W-1:BYTE_W];
                    q_byte_next[2] = hdr_word[BYTE_W-1:0];
                    q_hdr_next     = 3'b110;
                    q_cnt_next     = CNT_W'(3);
                end
                else
                begin
                    q_byte_next[0] = hdr_word[2*BYTE_W-1:BYTE_W];
                    q_byte_next[1] = hdr_word[BYTE_W-1:0];
                    q_byte_next[2] = '0;
                    q_hdr_next     = 3'b011;
                    q_cnt_next     = CNT_W'(2);
                end
            end
            else
            begin
                pending_next   = total[PAD_W-1:0];
                q_byte_next[0] = window[WIN_W-1 -: BYTE_W];
                q_byte_next[1] = window[WIN_W-BYTE_W-1 -: BYTE_W];
                q_byte_next[2] = '0;
                q_hdr_next     = '0;
                q_cnt_next     = nbytes;
                case (nbytes)
                    2'd0:    partial_next = window[WIN_W-1 -: BYTE_W];
                    2'd1:    partial_next = window[WIN_W-BYTE_W-1 -: BYTE_W];
                    default: partial_next = window[BYTE_W-1:0];
                endcase
            end
        end
        else if (cmd.advance)
        begin
            q_byte_next[0] = q_byte_reg[1];
            q_byte_next[1] = q_byte_reg[2];
            q_hdr_next     = {1'b0, q_hdr_reg[QUEUE_DEPTH-1:1]};
            q_cnt_next     = q_cnt_reg - CNT_W'(1);
        end
    end

    // Hold control and packing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_len_reg <= '0;
            partial_reg  <= '0;
            pending_reg  <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tree_len_reg <= cfg_wdata;
            end
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            q_cnt_reg   <= q_cnt_next;
        end
    end

    // Hold queue payload
    always_ff @(posedge clk)
    begin
        q_byte_reg <= q_byte_next;
        q_hdr_reg  <= q_hdr_next;
    end

    // A flush always queues the two header words, after the partial byte when bits are pending
    a_flush_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && func) |=> (q_cnt_reg == CNT_W'(2) || q_cnt_reg == CNT_W'(3)))
        else $error("flush queued wrong count");

    // A flush starts a fresh stream
    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && func) |=> (pending_reg == '0 && partial_reg == '0))
        else $error("flush left packing state");

    // Items enter only with an empty queue
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (q_cnt_reg == '0))
        else $error("load over pending words");

endmodule

>>> design/huffman_code_bit_packer.sv
// Huffman code bit packer top level: controller plus datapath.
// An item's first word is offered in the cycle after the item is taken.
// Each item causes 0..3 words, sent from the single output queue one word per
// cycle while out_ch.ready is high; no new item is taken until all are sent.
// Reset (rst_n, async low): stream empty, tree length 0, no words pending.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    hcbp_item_if.sink         in_ch,
    hcbp_result_if.source     out_ch,
    input  logic              cfg_we,
    input  logic [TREE_W-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // Sequence accept and send
    hcbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Pack bits and queue words
    hcbp_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (in_ch.func),
        .code_bits   (in_ch.code_bits),
        .code_length (in_ch.code_length),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_byte    (out_ch.out_byte),
        .is_header   (out_ch.is_header),
        .last        (out_ch.last)
    );

endmodule
